/* src/bscu_pkg.sv */
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bscu_pkg;

  // calibration register indexes
  typedef enum logic [2:0] {
    IDX_SENS_BASE   = 3'd0,
    IDX_OFFSET_BASE = 3'd1,
    IDX_SENS_TEMP   = 3'd2,
    IDX_OFFSET_TEMP = 3'd3,
    IDX_REF_TEMP    = 3'd4,
    IDX_TEMP_SLOPE  = 3'd5
  } cfg_idx_t;

  // calibration words as seen by the datapath
  typedef struct packed {
    logic [15:0] sens_base;    // C1
    logic [15:0] offset_base;  // C2
    logic [15:0] sens_temp;    // C3
    logic [15:0] offset_temp;  // C4
    logic [15:0] ref_temp;     // C5
    logic [15:0] temp_slope;   // C6
  } coeff_t;

  // reset values of the calibration words
  localparam logic [15:0] RST_SENS_BASE   = 16'd40127;
  localparam logic [15:0] RST_OFFSET_BASE = 16'd36924;
  localparam logic [15:0] RST_SENS_TEMP   = 16'd23317;
  localparam logic [15:0] RST_OFFSET_TEMP = 16'd23282;
  localparam logic [15:0] RST_REF_TEMP    = 16'd33464;
  localparam logic [15:0] RST_TEMP_SLOPE  = 16'd28312;

  // temperature thresholds and output limits
  localparam int TEMP_REF   = 2000;
  localparam int TEMP_COLD  = -1500;
  localparam int TEMP_LOW   = -4000;
  localparam int TEMP_HIGH  = 8500;
  localparam int PRES_LOW   = 1000;
  localparam int PRES_HIGH  = 120000;

endpackage

/* src/bscu_coeff_regs.sv */
// ----------------------------------------------------------------------------
// bscu_coeff_regs
// Calibration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bscu_coeff_regs
  import bscu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output coeff_t      coeff
);

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff.sens_base   <= RST_SENS_BASE;
      coeff.offset_base <= RST_OFFSET_BASE;
      coeff.sens_temp   <= RST_SENS_TEMP;
      coeff.offset_temp <= RST_OFFSET_TEMP;
      coeff.ref_temp    <= RST_REF_TEMP;
      coeff.temp_slope  <= RST_TEMP_SLOPE;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        IDX_SENS_BASE:   coeff.sens_base   <= cfg_data;
        IDX_OFFSET_BASE: coeff.offset_base <= cfg_data;
        IDX_SENS_TEMP:   coeff.sens_temp   <= cfg_data;
        IDX_OFFSET_TEMP: coeff.offset_temp <= cfg_data;
        IDX_REF_TEMP:    coeff.ref_temp    <= cfg_data;
        IDX_TEMP_SLOPE:  coeff.temp_slope  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/baro_sensor_compensation_unit.sv */
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Second-order temperature and pressure compensation of raw conversion pairs.
//
//   channel  signals                               direction
//   in       in_valid in_stall raw_pressure        item in, stall out
//            raw_temperature
//   out      out_valid out_stall temperature_centi item out, stall in
//            pressure_centi_mbar clamped
//   cfg      cfg_write cfg_index cfg_data          write only
//
// Nine register stages; one item enters per cycle while in_stall is low and
// leaves from stage 8. The wide D1 * SENS product is split into two partial
// products over two stages. Each stage moves on when it is empty or its
// successor moves, so bubbles close up under a stall and nothing is lost.
// Reset clears the stage valid bits and loads the calibration defaults.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit
  import bscu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [16:0]        pressure_centi_mbar,
  output logic               clamped,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NSTAGE = 9;

  coeff_t coeff;

  bscu_coeff_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  // stage valids and advance chain
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !v[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NSTAGE-1];

  // stage 0: dT = D2 - C5 * 2^8
  logic [23:0]        s0_d1;
  logic signed [24:0] s0_dt;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_d1 <= raw_pressure;
      s0_dt <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.ref_temp, 8'd0});
    end
  end

  // stage 1: products of dT with C6, C4, C3 and itself
  logic [23:0]        s1_d1;
  logic signed [41:0] s1_p6;
  logic signed [41:0] s1_p4;
  logic signed [41:0] s1_p3;
  logic signed [49:0] s1_dsq;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1  <= s0_d1;
      s1_p6  <= s0_dt * $signed({1'b0, coeff.temp_slope});
      s1_p4  <= s0_dt * $signed({1'b0, coeff.offset_temp});
      s1_p3  <= s0_dt * $signed({1'b0, coeff.sens_temp});
      s1_dsq <= s0_dt * s0_dt;
    end
  end

  // stage 2: first-order TEMP, OFF, SENS and T2
  logic signed [41:0] temp1_full;
  logic signed [41:0] off1;
  logic signed [41:0] sens1;

  always_comb begin
    temp1_full = 42'(TEMP_REF) + (s1_p6 >>> 23);
    off1       = $signed({10'd0, coeff.offset_base, 16'd0}) + (s1_p4 >>> 7);
    sens1      = $signed({11'd0, coeff.sens_base, 15'd0}) + (s1_p3 >>> 8);
  end

  logic [23:0]        s2_d1;
  logic signed [19:0] s2_temp;
  logic signed [41:0] s2_off;
  logic signed [41:0] s2_sens;
  logic [17:0]        s2_t2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1   <= s1_d1;
      s2_temp <= temp1_full[19:0];
      s2_off  <= off1;
      s2_sens <= sens1;
      s2_t2   <= s1_dsq[48:31];
    end
  end

  // stage 3: squares of the distances from the two thresholds
  logic signed [19:0] ta;
  logic signed [19:0] tb;
  logic signed [39:0] sqa_full;
  logic signed [39:0] sqb_full;

  always_comb begin
    ta       = s2_temp - 20'(TEMP_REF);
    tb       = s2_temp - 20'(TEMP_COLD);
    sqa_full = ta * ta;
    sqb_full = tb * tb;
  end

  logic [23:0]        s3_d1;
  logic signed [19:0] s3_temp;
  logic signed [41:0] s3_off;
  logic signed [41:0] s3_sens;
  logic [17:0]        s3_t2;
  logic [37:0]        s3_sqa;
  logic [37:0]        s3_sqb;
  logic               s3_warm_lt;
  logic               s3_cold_lt;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1      <= s2_d1;
      s3_temp    <= s2_temp;
      s3_off     <= s2_off;
      s3_sens    <= s2_sens;
      s3_t2      <= s2_t2;
      s3_sqa     <= sqa_full[37:0];
      s3_sqb     <= sqb_full[37:0];
      s3_warm_lt <= s2_temp < 20'(TEMP_REF);
      s3_cold_lt <= s2_temp < 20'(TEMP_COLD);
    end
  end

  // stage 4: second-order terms OFF2 and SENS2
  logic [41:0] sqa5;
  logic [41:0] sqb7;
  logic [41:0] sqb11;
  logic [41:0] off2;
  logic [41:0] sens2;

  always_comb begin
    sqa5  = {2'd0, s3_sqa, 2'd0} + {4'd0, s3_sqa};
    sqb7  = {1'd0, s3_sqb, 3'd0} - {4'd0, s3_sqb};
    sqb11 = {1'd0, s3_sqb, 3'd0} + {3'd0, s3_sqb, 1'd0} + {4'd0, s3_sqb};
    off2  = {1'd0, sqa5[41:1]};
    sens2 = {2'd0, sqa5[41:2]};
    if (s3_cold_lt) begin
      off2  = off2 + sqb7;
      sens2 = sens2 + {1'd0, sqb11[41:1]};
    end
    if (!s3_warm_lt) begin
      off2  = '0;
      sens2 = '0;
    end
  end

  logic [23:0]        s4_d1;
  logic signed [19:0] s4_temp;
  logic signed [41:0] s4_off;
  logic signed [41:0] s4_sens;
  logic [17:0]        s4_t2;
  logic [41:0]        s4_off2;
  logic [41:0]        s4_sens2;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1    <= s3_d1;
      s4_temp  <= s3_temp;
      s4_off   <= s3_off;
      s4_sens  <= s3_sens;
      s4_t2    <= s3_warm_lt ? s3_t2 : 18'd0;
      s4_off2  <= off2;
      s4_sens2 <= sens2;
    end
  end

  // stage 5: apply the second-order correction
  logic [23:0]        s5_d1;
  logic signed [19:0] s5_temp;
  logic signed [41:0] s5_off;
  logic signed [41:0] s5_sens;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_d1   <= s4_d1;
      s5_temp <= s4_temp - $signed({2'd0, s4_t2});
      s5_off  <= s4_off - $signed(s4_off2);
      s5_sens <= s4_sens - $signed(s4_sens2);
    end
  end

  // stage 6: partial products of D1 * SENS
  logic signed [19:0] s6_temp;
  logic signed [41:0] s6_off;
  logic [43:0]        s6_pl;
  logic signed [46:0] s6_ph;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_temp <= s5_temp;
      s6_off  <= s5_off;
      s6_pl   <= s5_d1 * s5_sens[19:0];
      s6_ph   <= $signed({1'b0, s5_d1}) * $signed(s5_sens[41:20]);
    end
  end

  // stage 7: sum partials, floor divide by 2^21
  logic signed [66:0] prod;

  always_comb begin
    prod = $signed({s6_ph, 20'd0}) + $signed({23'd0, s6_pl});
  end

  logic signed [19:0] s7_temp;
  logic signed [41:0] s7_off;
  logic signed [45:0] s7_x;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_x    <= prod[66:21];
    end
  end

  // stage 8: pressure, clamping and output register
  logic signed [45:0] pdiff;
  logic signed [45:0] pres;
  logic signed [14:0] temp_sat;
  logic [16:0]        pres_sat;
  logic               clip;

  always_comb begin
    pdiff    = s7_x - 46'(s7_off);
    pres     = pdiff >>> 15;
    clip     = 1'b0;
    temp_sat = s7_temp[14:0];
    pres_sat = pres[16:0];
    if (s7_temp < 20'(TEMP_LOW)) begin
      temp_sat = 15'(TEMP_LOW);
      clip     = 1'b1;
    end
    if (s7_temp > 20'(TEMP_HIGH)) begin
      temp_sat = 15'(TEMP_HIGH);
      clip     = 1'b1;
    end
    if (pres < 46'(PRES_LOW)) begin
      pres_sat = 17'(PRES_LOW);
      clip     = 1'b1;
    end
    if (pres > 46'(PRES_HIGH)) begin
      pres_sat = 17'(PRES_HIGH);
      clip     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      temperature_centi   <= temp_sat;
      pressure_centi_mbar <= pres_sat;
      clamped             <= clip;
    end
  end

endmodule
